### hw/rtl/pro_pkg.sv
// Package for the percent-range oscillator: result scaling constants,
// register indexes, controller states and the small structs shared by the modules.
// No dependencies.
package pro_pkg;

  localparam int RESULT_W   = 15;
  localparam int SEEN_W     = 7;
  localparam int WL_W       = 7;
  localparam int BB_W       = 6;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int BIT_IDX_W  = 4;

  localparam logic [RESULT_W-1:0]  FULL_SCALE  = 15'd25600;
  localparam logic [RESULT_W-1:0]  MID_SCALE   = 15'd12800;
  localparam logic [SEEN_W-1:0]    SEEN_MAX    = 7'd127;
  localparam logic [WL_W-1:0]      WL_RESET    = 7'd14;
  localparam logic [BIT_IDX_W-1:0] DIV_TOP_BIT = 4'd14;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BARS_BACK     = 1'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SETUP,
    ST_DIVIDE
  } pro_state_t;

  // per-cycle command to every bar cell
  typedef struct packed {
    logic insert;  // take the bar from the left neighbor (newest side)
    logic rotate;  // take the bar from the right neighbor (ring rotation)
  } cell_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;  // one-cycle pulse, quotient valid
  } div_status_t;

endpackage

### hw/rtl/pro_cell.sv
// One bar cell of the history chain: holds high, low and close of one bar.
// Shifts from the left on insert, from the right on rotate. Uses pro_pkg.
module pro_cell import pro_pkg::*; #(
  parameter int PRICE_BITS = 32
) (
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic [PRICE_BITS-1:0] prev_high,
  input  logic [PRICE_BITS-1:0] prev_low,
  input  logic [PRICE_BITS-1:0] prev_close,
  input  logic [PRICE_BITS-1:0] next_high,
  input  logic [PRICE_BITS-1:0] next_low,
  input  logic [PRICE_BITS-1:0] next_close,
  output logic [PRICE_BITS-1:0] high,
  output logic [PRICE_BITS-1:0] low,
  output logic [PRICE_BITS-1:0] close
);

  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      high  <= prev_high;
      low   <= prev_low;
      close <= prev_close;
    end else if (ctl.rotate) begin
      high  <= next_high;
      low   <= next_low;
      close <= next_close;
    end
  end

endmodule

### hw/rtl/pro_divider.sv
// Serial scaled divider: floor(25600 * num / den) for num < den.
// Per bit a doubling step and an add step, one add and compare each. Uses pro_pkg.
module pro_divider import pro_pkg::*; #(
  parameter int PRICE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [PRICE_BITS-1:0] num_in,
  input  logic [PRICE_BITS-1:0] den_in,
  output logic [RESULT_W-1:0]   quotient,
  output div_status_t           status
);

  logic [PRICE_BITS-1:0] num;
  logic [PRICE_BITS-1:0] den;
  logic [PRICE_BITS-1:0] rem;
  logic [BIT_IDX_W-1:0]  bit_idx;
  logic                  phase;
  logic                  busy;
  logic                  done;

  logic [PRICE_BITS-1:0] addend;
  logic [PRICE_BITS:0]   sum;
  logic [PRICE_BITS:0]   diff;
  logic                  ge;
  logic [PRICE_BITS-1:0] rem_step;

  // rem < den always, so rem + addend < 2*den: one conditional subtract
  assign addend   = phase ? num : rem;
  assign sum      = {1'b0, rem} + {1'b0, addend};
  assign diff     = sum - {1'b0, den};
  assign ge       = (sum >= {1'b0, den});
  assign rem_step = ge ? diff[PRICE_BITS-1:0] : sum[PRICE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      phase   <= 1'b0;
      bit_idx <= DIV_TOP_BIT;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        phase   <= 1'b0;
        bit_idx <= DIV_TOP_BIT;
      end else if (busy) begin
        phase <= ~phase;
        if (phase) begin
          if (bit_idx == '0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            bit_idx <= bit_idx - 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num      <= num_in;
      den      <= den_in;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      if (!phase) begin
        // doubling step
        rem      <= rem_step;
        quotient <= {quotient[RESULT_W-2:0], ge};
      end else if (FULL_SCALE[bit_idx]) begin
        // add num where the scale constant has a one bit
        rem      <= rem_step;
        quotient <= quotient + RESULT_W'(ge);
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

### hw/rtl/percent_range_oscillator_unit.sv
// Percent-range oscillator: bar history chain, window scan and serial divider.
// Uses pro_pkg, pro_cell and pro_divider.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one price bar per transaction:
//   high_price, low_price, close_price. Output channel (out_valid/out_ready)
//   returns one result per bar: percent_r = 25600*(C-L)/(H-L) saturated to
//   0..25600, and flat_range when H equals L. The first bar after reset
//   gives 12800.
//   Configuration: cfg_wen writes cfg_data into register cfg_index
//   (0 window_length, 1 bars_back); write only while the unit is idle.
//   Sequence: an accepted bar is shifted into a chain of DEPTH cells, then the
//   chain rotates once around while the cell at the head feeds the running
//   max/min, then the setup state and a serial divide of 15 quotient bits.
//   The result lands in the output register when the divide is done, or
//   straight from setup when setup settles it without a divide. The next
//   bar can be taken in the cycle after the result lands.
//   Stall: a waiting result stays in the output register while the next bar
//   is taken and processed; the unit holds only if a new result is ready
//   before the old one has left.
//   Reset: clears the bar count, the controller and the registers to their
//   defaults (window 14, bars back 0); no clearing pass is needed.
module percent_range_oscillator_unit import pro_pkg::*; #(
  parameter int DEPTH      = 64,
  parameter int PRICE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PRICE_BITS-1:0] high_price,
  input  logic [PRICE_BITS-1:0] low_price,
  input  logic [PRICE_BITS-1:0] close_price,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [RESULT_W-1:0]   percent_r,
  output logic                  flat_range
);

  localparam int IDX_W = $clog2(DEPTH);
  // wide enough for DEPTH and for back + length (bounded by 127)
  localparam int CW    = (IDX_W + 1 > 8) ? IDX_W + 1 : 8;

  // configuration
  logic [WL_W-1:0] window_length;
  logic [BB_W-1:0] bars_back;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WL_RESET;
      bars_back     <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_WINDOW_LENGTH: window_length <= cfg_data;
        REG_BARS_BACK:     bars_back     <= cfg_data[BB_W-1:0];
      endcase
    end
  end

  // controller
  pro_state_t state, state_next;
  cell_ctl_t  cell_ctl;
  logic       in_fire;
  logic       scan_last;
  logic       out_free;
  logic       early_done;  // result settled in setup, no divide
  logic       div_start;
  div_status_t div_status;
  logic       finish;

  logic [IDX_W-1:0] scan_idx;

  assign in_fire   = in_valid && in_ready;
  assign scan_last = (scan_idx == IDX_W'(DEPTH - 1));
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    state_next      = state;
    in_ready        = 1'b0;
    cell_ctl.insert = 1'b0;
    cell_ctl.rotate = 1'b0;
    div_start       = 1'b0;
    finish          = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready        = 1'b1;
        cell_ctl.insert = in_valid;
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        cell_ctl.rotate = 1'b1;
        if (scan_last) state_next = ST_SETUP;
      end
      ST_SETUP: begin
        if (early_done) begin
          if (out_free) begin
            finish     = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        // quotient holds after done, so a stalled output just waits here
        if ((div_status.done || !div_status.busy) && out_free) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // bar count and window bounds, settled at acceptance
  logic [SEEN_W-1:0] bars_seen;
  logic [SEEN_W-1:0] bars_seen_next;
  logic [CW-1:0]     avail;
  logic [CW-1:0]     back_c;
  logic [CW-1:0]     len_c;
  logic [CW-1:0]     room;
  logic [CW-1:0]     len_lim;
  logic [CW-1:0]     back_pos;
  logic [CW-1:0]     end_pos;
  logic              first_bar;

  assign bars_seen_next = (bars_seen == SEEN_MAX) ? bars_seen : bars_seen + 1'b1;

  always_comb begin
    avail   = (CW'(bars_seen_next) < CW'(DEPTH)) ? CW'(bars_seen_next) : CW'(DEPTH);
    back_c  = (CW'(bars_back) < avail) ? CW'(bars_back) : avail - 1'b1;
    len_c   = (window_length == '0) ? CW'(1) : CW'(window_length);
    room    = avail - back_c;
    len_lim = (len_c > room) ? room : len_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bars_seen <= '0;
      scan_idx  <= '0;
    end else if (in_fire) begin
      bars_seen <= bars_seen_next;
      scan_idx  <= '0;
    end else if (state == ST_SCAN) begin
      scan_idx  <= scan_last ? '0 : scan_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      back_pos  <= back_c;
      end_pos   <= back_c + len_lim;
      first_bar <= (bars_seen_next == SEEN_W'(1));
    end
  end

  // chain of bar cells: cell k holds the bar k back from the newest
  logic [PRICE_BITS-1:0] c_high  [DEPTH];
  logic [PRICE_BITS-1:0] c_low   [DEPTH];
  logic [PRICE_BITS-1:0] c_close [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [PRICE_BITS-1:0] p_high, p_low, p_close;
    logic [PRICE_BITS-1:0] n_high, n_low, n_close;
    if (k == 0) begin : g_head
      assign p_high  = high_price;
      assign p_low   = low_price;
      assign p_close = close_price;
    end else begin : g_body
      assign p_high  = c_high[k-1];
      assign p_low   = c_low[k-1];
      assign p_close = c_close[k-1];
    end
    if (k == DEPTH - 1) begin : g_tail
      assign n_high  = c_high[0];
      assign n_low   = c_low[0];
      assign n_close = c_close[0];
    end else begin : g_inner
      assign n_high  = c_high[k+1];
      assign n_low   = c_low[k+1];
      assign n_close = c_close[k+1];
    end
    pro_cell #(.PRICE_BITS(PRICE_BITS)) u_cell (
      .clk        (clk),
      .ctl        (cell_ctl),
      .prev_high  (p_high),
      .prev_low   (p_low),
      .prev_close (p_close),
      .next_high  (n_high),
      .next_low   (n_low),
      .next_close (n_close),
      .high       (c_high[k]),
      .low        (c_low[k]),
      .close      (c_close[k])
    );
  end

  // window scan over the head cell; one full turn of the ring restores the order
  logic [PRICE_BITS-1:0] hi_acc;
  logic [PRICE_BITS-1:0] lo_acc;
  logic [PRICE_BITS-1:0] cl_acc;
  logic [CW-1:0]         scan_pos;
  logic                  in_window;

  assign scan_pos  = CW'(scan_idx);
  assign in_window = (scan_pos >= back_pos) && (scan_pos < end_pos);

  always_ff @(posedge clk) begin
    if (state == ST_SCAN && in_window) begin
      if (scan_pos == back_pos) begin
        hi_acc <= c_high[0];
        lo_acc <= c_low[0];
        cl_acc <= c_close[0];
      end else begin
        if (c_high[0] > hi_acc) hi_acc <= c_high[0];
        if (c_low[0] < lo_acc)  lo_acc <= c_low[0];
      end
    end
  end

  // setup: special cases and divider operands
  logic                  is_flat;
  logic                  is_up;
  logic [RESULT_W-1:0]   early_pr;
  logic                  early_flat;
  logic [PRICE_BITS-1:0] div_num;
  logic [PRICE_BITS-1:0] div_den;
  logic [RESULT_W-1:0]   div_q;

  assign is_flat = (hi_acc == lo_acc);
  assign is_up   = (hi_acc > lo_acc);

  always_comb begin
    early_done = 1'b1;
    early_pr   = '0;
    early_flat = 1'b0;
    div_num    = cl_acc - lo_acc;
    div_den    = hi_acc - lo_acc;
    if (first_bar) begin
      early_pr = MID_SCALE;
    end else if (is_flat) begin
      early_flat = 1'b1;
    end else if (is_up) begin
      if (cl_acc <= lo_acc)      early_pr   = '0;
      else if (cl_acc >= hi_acc) early_pr   = FULL_SCALE;
      else                       early_done = 1'b0;
    end else begin
      // inverted range: both terms negated
      div_num = lo_acc - cl_acc;
      div_den = lo_acc - hi_acc;
      if (cl_acc >= lo_acc)      early_pr   = '0;
      else if (cl_acc <= hi_acc) early_pr   = FULL_SCALE;
      else                       early_done = 1'b0;
    end
  end

  pro_divider #(.PRICE_BITS(PRICE_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num_in   (div_num),
    .den_in   (div_den),
    .quotient (div_q),
    .status   (div_status)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      if (state == ST_SETUP) begin
        percent_r  <= early_pr;
        flat_range <= early_flat;
      end else begin
        percent_r  <= (div_q > FULL_SCALE) ? FULL_SCALE : div_q;
        flat_range <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == ST_SCAN) && (scan_idx == '0))
    else $error("scan did not start at the head cell");

  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    div_status.busy |-> (state == ST_DIVIDE))
    else $error("divider busy outside divide state");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (percent_r <= FULL_SCALE))
    else $error("percent_r above full scale");

  a_flat_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && flat_range) |-> (percent_r == '0))
    else $error("flat range with nonzero result");
`endif

endmodule
